// ===== hw/rtl/sktlb_pkg.sv =====
`default_nettype none
package sktlb_pkg;
   localparam int MaxEntries = 1024;
   localparam int AddrW = $clog2(MaxEntries);
   localparam int CountW = AddrW + 1;
   localparam int KeyW = 32;
   localparam int IdxW = 10;
   localparam int EntryW = KeyW + IdxW;

   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_LOAD  = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_SHORT_SIG = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   localparam logic [7:0] SigLenReset = 8'd4;
   localparam logic [7:0] SigLenMin   = 8'd4;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] sig_byte0;
      logic [7:0] sig_byte1;
      logic [7:0] sig_byte2;
      logic [7:0] sig_byte3;
      logic [31:0] target;
   } req_type_type;

   typedef struct packed {
      logic [1:0] status;
      logic [10:0] position;
      logic [9:0] entry_index;
      logic [10:0] distinct_count;
      logic [10:0] entry_count;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SRCH_RD, S_SRCH_WAIT, S_SRCH_CMP, S_EQ_RD, S_EQ_WAIT, S_EQ_CMP,
      S_SHIFT_RD, S_SHIFT_WAIT, S_SHIFT_WR, S_INSERT, S_IDX_RD, S_IDX_WAIT, S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;      // take the request item
      logic clear_tab;    // counts to zero
      logic srch_init;    // lo=0, hi=count
      logic srch_strict;  // compare > rather than >=
      logic srch_rd;      // read key at mid
      logic srch_step;    // narrow the range
      logic lb_save;      // keep lower bound result
      logic eq_rd;        // read key at lower bound
      logic eq_save;      // note key already present
      logic shift_init;   // ptr = count
      logic shift_rd;     // read entry at ptr-1
      logic shift_wr;     // write it at ptr, ptr--
      logic insert;       // write new entry, bump counts
      logic idx_rd;       // read entry at lower bound
      logic finish;       // build result
      logic [1:0] status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] req_type;
      logic srch_done;
      logic lb_in_range;
      logic shift_done;
      logic full;
      logic short_sig;
   } stat_type;
endpackage
`default_nettype wire

// ===== hw/rtl/sktlb_ram.sv =====
`default_nettype none
module sktlb_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/sktlb_ctrl.sv =====
`default_nettype none
module sktlb_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire sktlb_pkg::stat_type  stat,
   output sktlb_pkg::cmd_type        cmd
);
   sktlb_pkg::state_type state_ff, state_in;
   logic strict_ff, strict_in;
   logic rsp_valid_ff, rsp_valid_in;

   // busy while an item is in flight; output register frees on take
   assign req_stall = (state_ff != sktlb_pkg::S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sktlb_pkg::S_IDLE;
         strict_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         strict_ff    <= strict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in  = state_ff;
      strict_in = strict_ff;
      unique case (state_ff)
         sktlb_pkg::S_IDLE: begin
            if (req_valid && !req_stall) begin
               state_in  = sktlb_pkg::S_SRCH_RD;
               strict_in = 1'b0;
            end
         end
         sktlb_pkg::S_SRCH_RD: begin
            unique case (stat.req_type)
               sktlb_pkg::REQ_LOAD: begin
                  if (stat.short_sig || stat.full) state_in = sktlb_pkg::S_DONE;
                  else state_in = sktlb_pkg::S_SRCH_WAIT;
               end
               sktlb_pkg::REQ_QUERY: state_in = sktlb_pkg::S_SRCH_WAIT;
               default: state_in = sktlb_pkg::S_DONE;
            endcase
            if (stat.srch_done && state_in == sktlb_pkg::S_SRCH_WAIT) begin
               if (stat.req_type == sktlb_pkg::REQ_QUERY) state_in = sktlb_pkg::S_IDX_RD;
               else if (!strict_ff) state_in = sktlb_pkg::S_EQ_RD;
               else state_in = sktlb_pkg::S_SHIFT_RD;
            end
         end
         sktlb_pkg::S_SRCH_WAIT: state_in = sktlb_pkg::S_SRCH_CMP;
         sktlb_pkg::S_SRCH_CMP:  state_in = sktlb_pkg::S_SRCH_RD;
         sktlb_pkg::S_EQ_RD: begin
            if (stat.lb_in_range) state_in = sktlb_pkg::S_EQ_WAIT;
            else begin
               state_in  = sktlb_pkg::S_SRCH_RD;
               strict_in = 1'b1;
            end
         end
         sktlb_pkg::S_EQ_WAIT: state_in = sktlb_pkg::S_EQ_CMP;
         sktlb_pkg::S_EQ_CMP: begin
            state_in  = sktlb_pkg::S_SRCH_RD;
            strict_in = 1'b1;
         end
         sktlb_pkg::S_SHIFT_RD: begin
            if (stat.shift_done) state_in = sktlb_pkg::S_INSERT;
            else state_in = sktlb_pkg::S_SHIFT_WAIT;
         end
         sktlb_pkg::S_SHIFT_WAIT: state_in = sktlb_pkg::S_SHIFT_WR;
         sktlb_pkg::S_SHIFT_WR:   state_in = sktlb_pkg::S_SHIFT_RD;
         sktlb_pkg::S_INSERT:     state_in = sktlb_pkg::S_DONE;
         sktlb_pkg::S_IDX_RD: begin
            if (stat.lb_in_range) state_in = sktlb_pkg::S_IDX_WAIT;
            else state_in = sktlb_pkg::S_DONE;
         end
         sktlb_pkg::S_IDX_WAIT: state_in = sktlb_pkg::S_DONE;
         sktlb_pkg::S_DONE:     state_in = sktlb_pkg::S_IDLE;
         default:               state_in = sktlb_pkg::S_IDLE;
      endcase
   end

   // result register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == sktlb_pkg::S_DONE) rsp_valid_in = 1'b1;
   end

   // outputs
   always_comb begin
      cmd = '0;
      cmd.srch_strict = strict_ff;
      cmd.status = sktlb_pkg::ST_OK;
      unique case (state_ff)
         sktlb_pkg::S_IDLE: begin
            cmd.capture   = req_valid && !req_stall;
            cmd.srch_init = req_valid && !req_stall;
         end
         sktlb_pkg::S_SRCH_RD: begin
            cmd.srch_rd = 1'b1;
            if (stat.srch_done) begin
               cmd.lb_save    = !strict_ff;
               cmd.shift_init = strict_ff;
            end
            if (stat.req_type == sktlb_pkg::REQ_CLEAR) cmd.clear_tab = 1'b1;
         end
         sktlb_pkg::S_SRCH_CMP: cmd.srch_step = 1'b1;
         sktlb_pkg::S_EQ_RD: begin
            cmd.eq_rd = 1'b1;
            cmd.srch_init = !stat.lb_in_range;
         end
         sktlb_pkg::S_EQ_CMP: begin
            cmd.eq_save   = 1'b1;
            cmd.srch_init = 1'b1;
         end
         sktlb_pkg::S_SHIFT_RD:   cmd.shift_rd = 1'b1;
         // hold the read address so the data is still ptr-1 at the write
         sktlb_pkg::S_SHIFT_WAIT: cmd.shift_rd = 1'b1;
         sktlb_pkg::S_SHIFT_WR:   cmd.shift_wr = 1'b1;
         sktlb_pkg::S_INSERT:     cmd.insert = 1'b1;
         sktlb_pkg::S_IDX_RD:     cmd.idx_rd = 1'b1;
         sktlb_pkg::S_DONE: begin
            cmd.finish = 1'b1;
            if (stat.req_type == sktlb_pkg::REQ_LOAD) begin
               if (stat.short_sig) cmd.status = sktlb_pkg::ST_SHORT_SIG;
               else if (stat.full && !strict_ff) cmd.status = sktlb_pkg::ST_FULL;
            end
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

// ===== hw/rtl/sktlb_dp.sv =====
`default_nettype none
module sktlb_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sktlb_pkg::req_type_type req_data,
   input  wire logic [7:0]             sig_len,
   input  wire sktlb_pkg::cmd_type     cmd,
   output sktlb_pkg::stat_type         stat,
   output sktlb_pkg::rsp_type          rsp_data
);
   localparam int AW = sktlb_pkg::AddrW;
   localparam int CW = sktlb_pkg::CountW;
   localparam int KW = sktlb_pkg::KeyW;
   localparam int IW = sktlb_pkg::IdxW;

   logic [1:0]    type_ff;
   logic [KW-1:0] key_ff;
   logic [CW-1:0] count_ff, count_in, distinct_ff, distinct_in;
   logic [CW-1:0] lo_ff, hi_ff, lb_ff, ptr_ff;
   logic          present_ff;
   logic [CW-1:0] mid;
   sktlb_pkg::rsp_type rsp_ff;

   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [sktlb_pkg::EntryW-1:0] wr_data, rd_data;
   logic [KW-1:0]     rd_key;
   logic [IW-1:0]     rd_idx;

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign {rd_key, rd_idx} = rd_data;

   // one memory holds key and load index per sorted slot
   sktlb_ram #(.Width(sktlb_pkg::EntryW), .Depth(sktlb_pkg::MaxEntries)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   always_comb begin
      rd_addr = mid[AW-1:0];
      if (cmd.eq_rd || cmd.idx_rd) rd_addr = lb_ff[AW-1:0];
      else if (cmd.shift_rd) rd_addr = AW'(ptr_ff - CW'(1));
      wr_en   = cmd.shift_wr || cmd.insert;
      wr_addr = cmd.insert ? lo_ff[AW-1:0] : ptr_ff[AW-1:0];
      wr_data = cmd.insert ? {key_ff, count_ff[IW-1:0]} : rd_data;
   end

   // counts
   always_comb begin
      count_in    = count_ff;
      distinct_in = distinct_ff;
      if (cmd.clear_tab) begin
         count_in = '0;
         distinct_in = '0;
      end else if (cmd.insert) begin
         count_in = count_ff + CW'(1);
         if (!present_ff) distinct_in = distinct_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         distinct_ff <= '0;
      end else begin
         count_ff    <= count_in;
         distinct_ff <= distinct_in;
      end
   end

   // search, shift and result registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= req_data.req_type;
         key_ff  <= (req_data.req_type == sktlb_pkg::REQ_QUERY) ? req_data.target :
                    {req_data.sig_byte3, req_data.sig_byte2, req_data.sig_byte1,
                     req_data.sig_byte0};
         present_ff <= 1'b0;
      end
      if (cmd.srch_init) begin
         lo_ff <= '0;
         hi_ff <= count_ff;
      end
      if (cmd.srch_step) begin
         if (cmd.srch_strict ? (rd_key <= key_ff) : (rd_key < key_ff)) lo_ff <= mid + CW'(1);
         else hi_ff <= mid;
      end
      if (cmd.lb_save) lb_ff <= lo_ff;
      if (cmd.eq_save) present_ff <= (rd_key == key_ff);
      if (cmd.shift_init) ptr_ff <= count_ff;
      if (cmd.shift_wr) ptr_ff <= ptr_ff - CW'(1);
      if (cmd.finish) begin
         rsp_ff.status         <= cmd.status;
         rsp_ff.position       <= '0;
         rsp_ff.entry_index    <= '0;
         rsp_ff.distinct_count <= distinct_ff;
         rsp_ff.entry_count    <= count_ff;
         if (cmd.status == sktlb_pkg::ST_OK) begin
            if (type_ff == sktlb_pkg::REQ_LOAD) begin
               rsp_ff.position    <= lo_ff;
               rsp_ff.entry_index <= IW'(count_ff - CW'(1));
            end else if (type_ff == sktlb_pkg::REQ_QUERY) begin
               rsp_ff.position <= lb_ff;
               if (lb_ff < count_ff) rsp_ff.entry_index <= rd_idx;
            end
         end
      end
   end

   assign stat.req_type    = type_ff;
   assign stat.srch_done   = !(lo_ff < hi_ff);
   assign stat.lb_in_range = lb_ff < count_ff;
   assign stat.shift_done  = !(ptr_ff > lo_ff);
   assign stat.full        = count_ff >= CW'(sktlb_pkg::MaxEntries);
   assign stat.short_sig   = sig_len < sktlb_pkg::SigLenMin;
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/sorted_key_table_lower_bound.sv =====
// Operation: clear sets the counts to zero; query runs a lower-bound search
//   and reads the entry index; load runs a lower-bound and an upper-bound
//   search, then moves each entry above the insert point up one slot.
// Requests: one item at a time; a search of 1024 entries reads about 11 keys.
// Reset (synchronous): counts to zero, signature_length to 4; the table
//   contents are left as they are.
`default_nettype none
module sorted_key_table_lower_bound (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire sktlb_pkg::req_type_type req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output sktlb_pkg::rsp_type           rsp_data,
   input  wire logic                    csr_wr_en,
   input  wire logic [7:0]              csr_wr_data
);
   logic [7:0] sig_len_ff;
   sktlb_pkg::cmd_type  cmd;
   sktlb_pkg::stat_type stat;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) sig_len_ff <= sktlb_pkg::SigLenReset;
      else if (csr_wr_en) sig_len_ff <= csr_wr_data;
   end

   sktlb_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .stat, .cmd
   );

   sktlb_dp u_dp (
      .clock, .reset, .req_data, .sig_len(sig_len_ff), .cmd, .stat, .rsp_data
   );

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.insert && cmd.shift_wr)) else $error("insert during shift");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.distinct_count <= rsp_data.entry_count)
      else $error("distinct above count");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid) else $error("result lost");
endmodule
`default_nettype wire
